// ----- hdl/baro_pressure_temp_compensation_assert.svh -----
// Assertion macros for the barometer compensation block.
// Used by the top level; bodies are empty when SYNTHESIS is defined.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define BARO_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("baro compensation: implication check failed");
`define BARO_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("baro compensation: next-cycle check failed");
`else
`define BARO_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define BARO_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/baro_pkg.sv -----
// Shared types and constants for the barometer compensation pipeline.
// No dependencies; used by every other file of the block but the assertion header.
`default_nettype none

package baro_pkg;

   localparam int TEMP_REF   = 2000;
   localparam int TEMP_LOW   = -1500;
   localparam int PIPE_DEPTH = 9;

   typedef logic        [23:0] raw_type;
   typedef logic        [15:0] cal_word_type;
   typedef logic signed [24:0] dt_type;
   typedef logic signed [41:0] prod_type;
   typedef logic signed [49:0] sq_type;
   typedef logic signed [19:0] temp_type;
   typedef logic        [17:0] t2_type;
   typedef logic signed [39:0] wide_type;
   typedef logic        [38:0] corr_type;
   typedef logic        [35:0] sqr_type;
   typedef logic signed [15:0] centi_type;
   typedef logic        [17:0] press_type;
   typedef logic        [43:0] plo_type;
   typedef logic signed [44:0] phi_type;
   typedef logic signed [64:0] full_type;
   typedef logic signed [43:0] quot_type;
   typedef logic signed [44:0] diff_type;

   localparam centi_type TEMP_SAT_MAX = 16'sh7FFF;
   localparam centi_type TEMP_SAT_MIN = 16'sh8000;
   localparam press_type PRESS_MAX    = 18'h3FFFF;

   typedef enum logic [2:0] {
      CSR_SENS_COEFF     = 3'd0,
      CSR_OFFSET_COEFF   = 3'd1,
      CSR_SENS_TEMPCO    = 3'd2,
      CSR_OFFSET_TEMPCO  = 3'd3,
      CSR_REF_TEMP_WORD  = 3'd4,
      CSR_TEMP_SENS_WORD = 3'd5,
      CSR_SCALE_MODE     = 3'd6
   } baro_csr_type;

   typedef struct packed {
      cal_word_type sens_coeff;
      cal_word_type offset_coeff;
      cal_word_type sens_tempco;
      cal_word_type offset_tempco;
      cal_word_type ref_temp_word;
      cal_word_type temp_sens_word;
      logic         scale_mode;
   } baro_cal_type;

   typedef struct packed {
      raw_type pressure_raw;
      raw_type temperature_raw;
   } baro_sample_type;

   // first-order terms, TEMP not yet corrected
   typedef struct packed {
      raw_type  d1;
      temp_type temp;
      wide_type off;
      wide_type sens;
      t2_type   t2;
   } baro_first_type;

   // fully corrected terms, temperature already saturated
   typedef struct packed {
      raw_type   d1;
      centi_type temperature_centi;
      wide_type  off;
      wide_type  sens;
   } baro_second_type;

   typedef struct packed {
      centi_type temperature_centi;
      press_type pressure_pa;
   } baro_result_type;

endpackage

`default_nettype wire

// ----- hdl/baro_if.sv -----
// Request and response channel interfaces for the barometer compensation block.
// Depends on baro_pkg for the payload types.
`default_nettype none

interface baro_req_if;
   logic              valid;
   logic              ready;
   baro_pkg::raw_type pressure_raw;
   baro_pkg::raw_type temperature_raw;

   modport source (output valid, output pressure_raw, output temperature_raw, input ready);
   modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface baro_rsp_if;
   logic                valid;
   logic                ready;
   baro_pkg::centi_type temperature_centi;
   baro_pkg::press_type pressure_pa;

   modport source (output valid, output temperature_centi, output pressure_pa, input ready);
   modport sink   (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

`default_nettype wire

// ----- hdl/baro_first_order.sv -----
// Stages 1-3: dT, the first-order products and TEMP/OFF/SENS, plus dT^2 >> 31.
// Depends on baro_pkg.
`default_nettype none

module baro_first_order (
   input  logic                       clock,
   input  logic                       reset,
   input  baro_pkg::baro_cal_type     cal,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  baro_pkg::baro_sample_type  in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output baro_pkg::baro_first_type   out_data
);

   logic [2:0] valid_ff, valid_in, advance;

   // stage 1
   baro_pkg::dt_type   dt_ff, dt_in;
   baro_pkg::raw_type  d1_s1_ff;
   // stage 2
   baro_pkg::prod_type p6_ff, p6_in, p4_ff, p4_in, p3_ff, p3_in;
   baro_pkg::sq_type   dsq_ff, dsq_in;
   baro_pkg::raw_type  d1_s2_ff;
   logic signed [16:0] c6_s, c4_s, c3_s;
   // stage 3
   baro_pkg::temp_type temp_ff, temp_in;
   baro_pkg::wide_type off_ff, off_in, sens_ff, sens_in;
   baro_pkg::t2_type   t2_ff, t2_in;
   baro_pkg::raw_type  d1_s3_ff;
   logic [39:0]        off_base, sens_base;

   // advance a stage when it is empty or its successor moves
   always_comb begin
      advance[2] = !valid_ff[2] || out_ready;
      advance[1] = !valid_ff[1] || advance[2];
      advance[0] = !valid_ff[0] || advance[1];
      valid_in[0] = advance[0] ? in_valid    : valid_ff[0];
      valid_in[1] = advance[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = advance[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_ready  = advance[0];
   assign out_valid = valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: dT = D2 - C5*256
   assign dt_in = baro_pkg::dt_type'({1'b0, in_data.temperature_raw})
                - baro_pkg::dt_type'({1'b0, cal.ref_temp_word, 8'h00});

   // stage 2: products with dT
   assign c6_s   = signed'({1'b0, cal.temp_sens_word});
   assign c4_s   = signed'({1'b0, cal.offset_tempco});
   assign c3_s   = signed'({1'b0, cal.sens_tempco});
   assign p6_in  = baro_pkg::prod_type'(dt_ff) * baro_pkg::prod_type'(c6_s);
   assign p4_in  = baro_pkg::prod_type'(dt_ff) * baro_pkg::prod_type'(c4_s);
   assign p3_in  = baro_pkg::prod_type'(dt_ff) * baro_pkg::prod_type'(c3_s);
   assign dsq_in = baro_pkg::sq_type'(dt_ff) * baro_pkg::sq_type'(dt_ff);

   // stage 3: scale and add the reference terms
   always_comb begin
      off_base  = cal.scale_mode ? {7'b0, cal.offset_coeff, 17'b0}
                                 : {8'b0, cal.offset_coeff, 16'b0};
      sens_base = cal.scale_mode ? {8'b0, cal.sens_coeff, 16'b0}
                                 : {9'b0, cal.sens_coeff, 15'b0};
      temp_in   = baro_pkg::temp_type'(baro_pkg::TEMP_REF)
                + baro_pkg::temp_type'(p6_ff >>> 23);
      off_in    = signed'(off_base)
                + baro_pkg::wide_type'(cal.scale_mode ? (p4_ff >>> 6) : (p4_ff >>> 7));
      sens_in   = signed'(sens_base)
                + baro_pkg::wide_type'(cal.scale_mode ? (p3_ff >>> 7) : (p3_ff >>> 8));
      // dT^2 is never negative and stays below 2^48
      t2_in     = dsq_ff[48:31];
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= in_data.pressure_raw;
      end
      if (advance[1]) begin
         p6_ff    <= p6_in;
         p4_ff    <= p4_in;
         p3_ff    <= p3_in;
         dsq_ff   <= dsq_in;
         d1_s2_ff <= d1_s1_ff;
      end
      if (advance[2]) begin
         temp_ff  <= temp_in;
         off_ff   <= off_in;
         sens_ff  <= sens_in;
         t2_ff    <= t2_in;
         d1_s3_ff <= d1_s2_ff;
      end
   end

   assign out_data.d1   = d1_s3_ff;
   assign out_data.temp = temp_ff;
   assign out_data.off  = off_ff;
   assign out_data.sens = sens_ff;
   assign out_data.t2   = t2_ff;

endmodule

`default_nettype wire

// ----- hdl/baro_second_order.sv -----
// Stages 4-6: low-temperature correction of TEMP, OFF and SENS, TEMP saturation.
// Depends on baro_pkg.
`default_nettype none

module baro_second_order (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  baro_pkg::baro_first_type   in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output baro_pkg::baro_second_type  out_data
);

   logic [2:0] valid_ff, valid_in, advance;

   // stage 4
   baro_pkg::temp_type a_diff, b_diff;
   baro_pkg::wide_type a_sq, b_sq;
   baro_pkg::sqr_type  t_ff, t_in, u_ff, u_in;
   logic               cold_s4_ff, cold_in, frigid_ff, frigid_in;
   baro_pkg::temp_type temp_s4_ff;
   baro_pkg::wide_type off_s4_ff, sens_s4_ff;
   baro_pkg::t2_type   t2_s4_ff;
   baro_pkg::raw_type  d1_s4_ff;
   // stage 5
   baro_pkg::corr_type t5, u7, u11;
   baro_pkg::corr_type off2_ff, off2_in, sens2_ff, sens2_in;
   logic               cold_s5_ff;
   baro_pkg::temp_type temp_s5_ff;
   baro_pkg::wide_type off_s5_ff, sens_s5_ff;
   baro_pkg::t2_type   t2_s5_ff;
   baro_pkg::raw_type  d1_s5_ff;
   // stage 6
   baro_pkg::temp_type  temp_adj;
   baro_pkg::centi_type centi_ff, centi_in;
   baro_pkg::wide_type  off_s6_ff, off_in, sens_s6_ff, sens_in;
   baro_pkg::raw_type   d1_s6_ff;

   always_comb begin
      advance[2] = !valid_ff[2] || out_ready;
      advance[1] = !valid_ff[1] || advance[2];
      advance[0] = !valid_ff[0] || advance[1];
      valid_in[0] = advance[0] ? in_valid    : valid_ff[0];
      valid_in[1] = advance[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = advance[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_ready  = advance[0];
   assign out_valid = valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage 4: distances from the two temperature knees, squared
   always_comb begin
      a_diff    = in_data.temp - baro_pkg::temp_type'(baro_pkg::TEMP_REF);
      b_diff    = in_data.temp - baro_pkg::temp_type'(baro_pkg::TEMP_LOW);
      a_sq      = baro_pkg::wide_type'(a_diff) * baro_pkg::wide_type'(a_diff);
      b_sq      = baro_pkg::wide_type'(b_diff) * baro_pkg::wide_type'(b_diff);
      t_in      = a_sq[35:0];
      u_in      = b_sq[35:0];
      cold_in   = in_data.temp < baro_pkg::temp_type'(baro_pkg::TEMP_REF);
      frigid_in = in_data.temp < baro_pkg::temp_type'(baro_pkg::TEMP_LOW);
   end

   // stage 5: OFF2 = 2.5t (+ 7u), SENS2 = 1.25t (+ 5.5u), all by shift, add and subtract
   always_comb begin
      t5       = {1'b0, t_ff, 2'b00} + baro_pkg::corr_type'(t_ff);
      u7       = {u_ff, 3'b000} - baro_pkg::corr_type'(u_ff);
      u11      = {u_ff, 3'b000} + {2'b00, u_ff, 1'b0} + baro_pkg::corr_type'(u_ff);
      off2_in  = {1'b0, t5[38:1]} + (frigid_ff ? u7 : '0);
      sens2_in = {2'b00, t5[38:2]} + (frigid_ff ? {1'b0, u11[38:1]} : '0);
   end

   // stage 6: apply the corrections below the reference, then saturate TEMP
   always_comb begin
      temp_adj = cold_s5_ff ? temp_s5_ff - baro_pkg::temp_type'({2'b00, t2_s5_ff})
                            : temp_s5_ff;
      off_in   = cold_s5_ff ? off_s5_ff - baro_pkg::wide_type'({1'b0, off2_ff})
                            : off_s5_ff;
      sens_in  = cold_s5_ff ? sens_s5_ff - baro_pkg::wide_type'({1'b0, sens2_ff})
                            : sens_s5_ff;
      priority if ((&temp_adj[19:15]) || !(|temp_adj[19:15])) begin
         centi_in = temp_adj[15:0];
      end else if (temp_adj[19]) begin
         centi_in = baro_pkg::TEMP_SAT_MIN;
      end else begin
         centi_in = baro_pkg::TEMP_SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         t_ff       <= t_in;
         u_ff       <= u_in;
         cold_s4_ff <= cold_in;
         frigid_ff  <= frigid_in;
         temp_s4_ff <= in_data.temp;
         off_s4_ff  <= in_data.off;
         sens_s4_ff <= in_data.sens;
         t2_s4_ff   <= in_data.t2;
         d1_s4_ff   <= in_data.d1;
      end
      if (advance[1]) begin
         off2_ff    <= off2_in;
         sens2_ff   <= sens2_in;
         cold_s5_ff <= cold_s4_ff;
         temp_s5_ff <= temp_s4_ff;
         off_s5_ff  <= off_s4_ff;
         sens_s5_ff <= sens_s4_ff;
         t2_s5_ff   <= t2_s4_ff;
         d1_s5_ff   <= d1_s4_ff;
      end
      if (advance[2]) begin
         centi_ff   <= centi_in;
         off_s6_ff  <= off_in;
         sens_s6_ff <= sens_in;
         d1_s6_ff   <= d1_s5_ff;
      end
   end

   assign out_data.d1                = d1_s6_ff;
   assign out_data.temperature_centi = centi_ff;
   assign out_data.off               = off_s6_ff;
   assign out_data.sens              = sens_s6_ff;

endmodule

`default_nettype wire

// ----- hdl/baro_pressure.sv -----
// Stages 7-9: P = ((D1*SENS >> 21) - OFF) >> 15 with clamping; stage 9 is the output register.
// Depends on baro_pkg.
`default_nettype none

module baro_pressure (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  baro_pkg::baro_second_type  in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output baro_pkg::baro_result_type  out_data
);

   logic [2:0] valid_ff, valid_in, advance;

   // stage 7: D1*SENS as two partial products
   baro_pkg::plo_type   lo_ff, lo_in;
   baro_pkg::phi_type   hi_ff, hi_in;
   baro_pkg::wide_type  off_s7_ff;
   baro_pkg::centi_type centi_s7_ff;
   // stage 8
   baro_pkg::full_type  full_sum;
   baro_pkg::quot_type  q_ff, q_in;
   baro_pkg::wide_type  off_s8_ff;
   baro_pkg::centi_type centi_s8_ff;
   // stage 9
   baro_pkg::diff_type  diff;
   baro_pkg::press_type pa_ff, pa_in;
   baro_pkg::centi_type centi_s9_ff;

   always_comb begin
      advance[2] = !valid_ff[2] || out_ready;
      advance[1] = !valid_ff[1] || advance[2];
      advance[0] = !valid_ff[0] || advance[1];
      valid_in[0] = advance[0] ? in_valid    : valid_ff[0];
      valid_in[1] = advance[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = advance[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_ready  = advance[0];
   assign out_valid = valid_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // low 20 bits of SENS unsigned, upper 20 bits signed
   assign lo_in = baro_pkg::plo_type'(in_data.d1) * baro_pkg::plo_type'(in_data.sens[19:0]);
   assign hi_in = baro_pkg::phi_type'(signed'({1'b0, in_data.d1}))
                * baro_pkg::phi_type'(signed'(in_data.sens[39:20]));

   // recombine and drop 21 bits
   always_comb begin
      full_sum = (baro_pkg::full_type'(hi_ff) <<< 20)
               + baro_pkg::full_type'(signed'({1'b0, lo_ff}));
      q_in     = baro_pkg::quot_type'(full_sum >>> 21);
   end

   // subtract OFF, drop 15 bits, clamp to the 18-bit range
   always_comb begin
      diff = baro_pkg::diff_type'(q_ff) - baro_pkg::diff_type'(off_s8_ff);
      priority if (diff[44]) begin
         pa_in = '0;
      end else if (|diff[43:33]) begin
         pa_in = baro_pkg::PRESS_MAX;
      end else begin
         pa_in = diff[32:15];
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         off_s7_ff   <= in_data.off;
         centi_s7_ff <= in_data.temperature_centi;
      end
      if (advance[1]) begin
         q_ff        <= q_in;
         off_s8_ff   <= off_s7_ff;
         centi_s8_ff <= centi_s7_ff;
      end
      if (advance[2]) begin
         pa_ff       <= pa_in;
         centi_s9_ff <= centi_s8_ff;
      end
   end

   assign out_data.temperature_centi = centi_s9_ff;
   assign out_data.pressure_pa       = pa_ff;

endmodule

`default_nettype wire

// ----- hdl/baro_pressure_temp_compensation.sv -----
// Barometric pressure and temperature compensation, top level. Depends on baro_pkg,
// baro_if, baro_first_order, baro_second_order, baro_pressure and the assertion header.
// Each request carries one raw pressure/temperature conversion pair (D1, D2) and
// yields exactly one response: temperature in 0.01 degC, saturated to 16 bits
// signed, and pressure in Pa, clamped to 0..262143. The datasheet second-order
// correction applies below 20.00 degC and again below -15.00 degC. The datapath is
// a nine-stage pipeline (three stages each for first-order terms, low-temperature
// correction and the final pressure product), so a request is accepted every cycle
// while the response side keeps up. Each stage holds its payload while stalled
// and bubbles collapse, so requests keep flowing while a finished response waits
// until the pipeline is full. Calibration words C1..C6 and the scaling mode are
// written through the csr port at indexes 0..6 (index 7 is ignored); write them
// only while no request is in flight. Only the valid flags, the calibration
// registers and the in-flight count reset to zero; the datapath registers do not.
`default_nettype none
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation (
   input  logic               clock,
   input  logic               reset,
   baro_req_if.sink           req_chan,
   baro_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wr_data
);

   localparam int FLIGHT_W = $clog2(baro_pkg::PIPE_DEPTH + 1);

   baro_pkg::baro_cal_type    cal_ff, cal_in;
   baro_pkg::baro_sample_type sample;
   baro_pkg::baro_first_type  first_data;
   baro_pkg::baro_second_type second_data;
   baro_pkg::baro_result_type result_data;
   logic first_valid, first_ready, second_valid, second_ready;

   logic                req_accept, rsp_accept;
   logic [FLIGHT_W-1:0] in_flight_ff, in_flight_in, depth_full;

   // calibration registers: hold unless written, ignore the unused index
   always_comb begin
      cal_in = cal_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            baro_pkg::CSR_SENS_COEFF:     cal_in.sens_coeff     = csr_wr_data;
            baro_pkg::CSR_OFFSET_COEFF:   cal_in.offset_coeff   = csr_wr_data;
            baro_pkg::CSR_SENS_TEMPCO:    cal_in.sens_tempco    = csr_wr_data;
            baro_pkg::CSR_OFFSET_TEMPCO:  cal_in.offset_tempco  = csr_wr_data;
            baro_pkg::CSR_REF_TEMP_WORD:  cal_in.ref_temp_word  = csr_wr_data;
            baro_pkg::CSR_TEMP_SENS_WORD: cal_in.temp_sens_word = csr_wr_data;
            baro_pkg::CSR_SCALE_MODE:     cal_in.scale_mode     = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   assign sample.pressure_raw    = req_chan.pressure_raw;
   assign sample.temperature_raw = req_chan.temperature_raw;

   // stages 1-3: dT, first-order TEMP, OFF and SENS
   baro_first_order u_first (
      .clock     (clock),
      .reset     (reset),
      .cal       (cal_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (sample),
      .out_valid (first_valid),
      .out_ready (first_ready),
      .out_data  (first_data)
   );

   // stages 4-6: low-temperature correction
   baro_second_order u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_ready  (first_ready),
      .in_data   (first_data),
      .out_valid (second_valid),
      .out_ready (second_ready),
      .out_data  (second_data)
   );

   // stages 7-9: pressure product and output register
   baro_pressure u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (second_valid),
      .in_ready  (second_ready),
      .in_data   (second_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (result_data)
   );

   assign rsp_chan.temperature_centi = result_data.temperature_centi;
   assign rsp_chan.pressure_pa       = result_data.pressure_pa;

   // track requests in flight for the checks below
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;
   assign depth_full = FLIGHT_W'(baro_pkg::PIPE_DEPTH);

   always_comb begin
      unique case ({req_accept, rsp_accept})
         2'b10:   in_flight_in = in_flight_ff + 1'b1;
         2'b01:   in_flight_in = in_flight_ff - 1'b1;
         default: in_flight_in = in_flight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // never more requests in flight than pipeline stages
   `BARO_ASSERT_IMPLY(a_flight_bound, clock, reset, 1'b1, in_flight_ff <= depth_full)
   // no response without an accepted request behind it
   `BARO_ASSERT_IMPLY(a_no_orphan_rsp, clock, reset, in_flight_ff == '0, !rsp_chan.valid)
   // a full, stalled pipeline refuses new requests
   `BARO_ASSERT_IMPLY(a_full_blocks, clock, reset, (in_flight_ff == depth_full) && !rsp_chan.ready, !req_chan.ready)
   // a request entering an empty pipeline cannot come out on the next cycle
   `BARO_ASSERT_NEXT(a_min_latency, clock, reset, (in_flight_ff == '0) && req_accept, !rsp_chan.valid)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the barometer compensation pipeline.
// Depends on baro_pkg, the baro_req_if/baro_rsp_if channel interfaces and the top level.
// Predicts each response in 64-bit integer arithmetic and checks responses in order.
module tb_top;
   import baro_pkg::*;

   localparam int          STALL_LIMIT    = 1000;
   localparam int          LONG_HOLD      = 120;
   localparam int          RANDOM_PHASES  = 12;
   localparam logic [2:0]  CSR_UNUSED_IDX = 3'd7;

   // datasheet-style typical calibration words C1..C6
   localparam logic [15:0] TYP_C1 = 16'd40127;
   localparam logic [15:0] TYP_C2 = 16'd36924;
   localparam logic [15:0] TYP_C3 = 16'd23317;
   localparam logic [15:0] TYP_C4 = 16'd23282;
   localparam logic [15:0] TYP_C5 = 16'd33464;
   localparam logic [15:0] TYP_C6 = 16'd28312;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;

   baro_req_if req_bus ();
   baro_rsp_if rsp_bus ();

   baro_pressure_temp_compensation i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the calibration registers, updated on every csr write.
   baro_cal_type    cal_shadow;
   baro_sample_type pending_samples[$];
   baro_result_type expected_results[$];
   int              error_count;
   int              requests_taken;

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Second-order compensation of one D1/D2 pair under the current shadow calibration.
   // All terms are 64-bit signed and every shift is arithmetic (floor).
   function automatic baro_result_type compensate_sample(input raw_type d1_raw,
                                                         input raw_type d2_raw);
      baro_result_type res;
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t, u, t2, off2, sens2, p;
      int     m;
      d1 = d1_raw;
      d2 = d2_raw;
      c1 = cal_shadow.sens_coeff;
      c2 = cal_shadow.offset_coeff;
      c3 = cal_shadow.sens_tempco;
      c4 = cal_shadow.offset_tempco;
      c5 = cal_shadow.ref_temp_word;
      c6 = cal_shadow.temp_sens_word;
      m  = cal_shadow.scale_mode ? 1 : 0;

      // first order; mode 1 doubles the OFF and SENS scaling
      dt   = d2 - c5 * 256;
      temp = TEMP_REF + ((dt * c6) >>> 23);
      off  = (c2 <<< (16 + m)) + ((c4 * dt) >>> (7 - m));
      sens = (c1 <<< (15 + m)) + ((c3 * dt) >>> (8 - m));

      // low-temperature correction; t and u use TEMP before T2 comes off
      if (temp < TEMP_REF) begin
         t     = (temp - TEMP_REF) * (temp - TEMP_REF);
         t2    = (dt * dt) >>> 31;
         off2  = (5 * t) >>> 1;
         sens2 = (5 * t) >>> 2;
         if (temp < TEMP_LOW) begin
            u     = (temp - TEMP_LOW) * (temp - TEMP_LOW);
            off2  = off2 + 7 * u;
            sens2 = sens2 + ((11 * u) >>> 1);
         end
         temp = temp - t2;
         off  = off - off2;
         sens = sens - sens2;
      end

      p = (((d1 * sens) >>> 21) - off) >>> 15;

      if (temp > longint'(TEMP_SAT_MAX))
         res.temperature_centi = TEMP_SAT_MAX;
      else if (temp < longint'(TEMP_SAT_MIN))
         res.temperature_centi = TEMP_SAT_MIN;
      else
         res.temperature_centi = temp[15:0];

      if (p < 0)
         res.pressure_pa = '0;
      else if (p > longint'(PRESS_MAX))
         res.pressure_pa = PRESS_MAX;
      else
         res.pressure_pa = p[17:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: pops pending samples, sends them in bursts with random gaps,
   // and records the prediction the moment a request is accepted.
   // ---------------------------------------------------------------------------
   int burst_left;
   int gap_left;
   baro_sample_type next_sample;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         requests_taken <= 0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(compensate_sample(req_bus.pressure_raw,
                                                         req_bus.temperature_raw));
            requests_taken <= requests_taken + 1;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered request until it is taken
         end else if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (pending_samples.size() > 0) begin
            next_sample = pending_samples.pop_front();
            req_bus.valid           <= 1'b1;
            req_bus.pressure_raw    <= next_sample.pressure_raw;
            req_bus.temperature_raw <= next_sample.temperature_raw;
            if (burst_left <= 1) begin
               // new burst; a quarter of the bursts follow on without a gap
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response receiver: stalls on a rotating 8-bit pattern that is redrawn each time
   // its random run length is used up. After 200 accepted requests, and every 300
   // after that, it also holds off so the pipeline fills and pushes back on the
   // request side; short random hold-offs come on top.
   // ---------------------------------------------------------------------------
   int         hold_left;
   int         next_hold_mark;
   int         pattern_left;
   logic [7:0] stall_pattern;
   logic [2:0] pattern_pos;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left      = 0;
         next_hold_mark = 200;
         pattern_left   = 0;
         stall_pattern  = 8'hFF;
         pattern_pos    = '0;
      end else begin
         if (hold_left == 0 && requests_taken >= next_hold_mark) begin
            hold_left      = LONG_HOLD;
            next_hold_mark = next_hold_mark + 300;
         end else if (hold_left == 0 && $urandom_range(0, 399) == 0) begin
            hold_left = $urandom_range(20, 50);
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pattern = 8'hFF;
                  1:       stall_pattern = 8'($urandom);
                  2:       stall_pattern = 8'($urandom) & 8'($urandom);
                  default: stall_pattern = 8'($urandom) | 8'($urandom);
               endcase
               if (stall_pattern == 8'h00)
                  stall_pattern = 8'h01;
               pattern_left = $urandom_range(16, 64);
            end
            rsp_bus.ready <= stall_pattern[pattern_pos];
            pattern_pos++;
            pattern_left--;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: compare every accepted response against the oldest prediction.
   // ---------------------------------------------------------------------------
   baro_result_type oldest_expected;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            flag_error($sformatf("response with no request outstanding: temp %0d press %0d",
                                 rsp_bus.temperature_centi, rsp_bus.pressure_pa));
         end else begin
            oldest_expected = expected_results.pop_front();
            if (rsp_bus.temperature_centi !== oldest_expected.temperature_centi)
               flag_error($sformatf("temperature_centi got %0d, expected %0d",
                                    rsp_bus.temperature_centi,
                                    oldest_expected.temperature_centi));
            if (rsp_bus.pressure_pa !== oldest_expected.pressure_pa)
               flag_error($sformatf("pressure_pa got %0d, expected %0d",
                                    rsp_bus.pressure_pa, oldest_expected.pressure_pa));
         end
      end
   end

   // Watchdog: end the run if no request and no response moves for too long.
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("baro_pressure_temp_compensation verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic write_cal_reg(input logic [2:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_SENS_COEFF:     cal_shadow.sens_coeff     = data;
         CSR_OFFSET_COEFF:   cal_shadow.offset_coeff   = data;
         CSR_SENS_TEMPCO:    cal_shadow.sens_tempco    = data;
         CSR_OFFSET_TEMPCO:  cal_shadow.offset_tempco  = data;
         CSR_REF_TEMP_WORD:  cal_shadow.ref_temp_word  = data;
         CSR_TEMP_SENS_WORD: cal_shadow.temp_sens_word = data;
         CSR_SCALE_MODE:     cal_shadow.scale_mode     = data[0];
         default: ; // unused index: the block drops the write
      endcase
   endtask

   task automatic load_calibration(input logic [15:0] c1, input logic [15:0] c2,
                                   input logic [15:0] c3, input logic [15:0] c4,
                                   input logic [15:0] c5, input logic [15:0] c6,
                                   input logic [15:0] mode_word);
      write_cal_reg(CSR_SENS_COEFF,     c1);
      write_cal_reg(CSR_OFFSET_COEFF,   c2);
      write_cal_reg(CSR_SENS_TEMPCO,    c3);
      write_cal_reg(CSR_OFFSET_TEMPCO,  c4);
      write_cal_reg(CSR_REF_TEMP_WORD,  c5);
      write_cal_reg(CSR_TEMP_SENS_WORD, c6);
      write_cal_reg(CSR_SCALE_MODE,     mode_word);
   endtask

   task automatic queue_sample(input raw_type d1, input raw_type d2);
      baro_sample_type s;
      s.pressure_raw    = d1;
      s.temperature_raw = d2;
      pending_samples.push_back(s);
   endtask

   // Drain: every request sent and every response back, then let the pipe settle.
   // Look between edges, once the driver's pop and its valid update have both landed.
   task automatic wait_until_idle();
      while (pending_samples.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_cal_word();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic raw_type pick_pressure_raw();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         1:       return 24'($urandom_range(7000000, 11000000));
         default: return 24'($urandom);
      endcase
   endfunction

   // Cluster two in five D2 values around C5*256 at random distances, so the TEMP = 20.00 and
   // TEMP = -15.00 boundaries get crossed for whatever C6 is loaded.
   function automatic raw_type pick_temperature_raw();
      longint center, delta, val;
      int     span;
      center = cal_shadow.ref_temp_word;
      center = center * 256;
      case ($urandom_range(0, 4))
         0, 1: return 24'($urandom);
         2:    return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         default: begin
            span  = $urandom_range(0, 23);
            delta = $urandom & ((32'd1 << span) - 1);
            if ($urandom_range(0, 1))
               delta = -delta;
            val = center + delta;
            if (val < 0)
               val = 0;
            else if (val > 64'd16777215)
               val = 64'd16777215;
            return val[23:0];
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   int n_items;

   initial begin
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_index               = '0;
      csr_wr_data             = '0;
      req_bus.valid           = 1'b0;
      req_bus.pressure_raw    = '0;
      req_bus.temperature_raw = '0;
      rsp_bus.ready           = 1'b0;
      cal_shadow              = '0;
      error_count             = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all calibration words zero after reset: arithmetic runs as is
      queue_sample(24'h000000, 24'h000000);
      queue_sample(24'hFFFFFF, 24'hFFFFFF);
      wait_until_idle();

      // typical calibration, standard scaling: reference point, the 20.00 degC
      // boundary on both sides, the -15.00 degC region and raw extremes
      load_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6, 16'h0000);
      queue_sample(24'd9085466, 24'd8569150);
      queue_sample(24'd9085466, 24'd8566784);
      queue_sample(24'd9085466, 24'd8566783);
      queue_sample(24'd9085466, 24'd7400000);
      queue_sample(24'h000000,  24'd8569150);
      queue_sample(24'hFFFFFF,  24'd8569150);
      queue_sample(24'hFFFFFF,  24'h000000);
      queue_sample(24'h000000,  24'hFFFFFF);
      wait_until_idle();

      // write to the unused index must not disturb anything; then doubled scaling
      // with only bit 0 of the mode word counting
      write_cal_reg(CSR_UNUSED_IDX, 16'hFFFF);
      queue_sample(24'd9085466, 24'd8569150);
      wait_until_idle();
      write_cal_reg(CSR_SCALE_MODE, 16'h0003);
      queue_sample(24'd9085466, 24'd8569150);
      queue_sample(24'd9085466, 24'd7400000);
      wait_until_idle();

      // every word at its maximum, doubled scaling: low temperature saturation
      load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
      queue_sample(24'hFFFFFF, 24'h000000);
      queue_sample(24'hFFFFFF, 24'hFFFFFF);
      queue_sample(24'h000000, 24'h000000);
      wait_until_idle();

      // C5 zero, C6 maximal: high temperature saturation and the upper pressure clamp
      load_calibration(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFE);
      queue_sample(24'hFFFFFF, 24'hFFFFFF);
      queue_sample(24'd123456, 24'h000000);
      wait_until_idle();

      // random phases, each with its own calibration
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 2))
            0: load_calibration(TYP_C1 ^ 16'($urandom_range(0, 4095)),
                                TYP_C2 ^ 16'($urandom_range(0, 4095)),
                                TYP_C3 ^ 16'($urandom_range(0, 4095)),
                                TYP_C4 ^ 16'($urandom_range(0, 4095)),
                                TYP_C5 ^ 16'($urandom_range(0, 4095)),
                                TYP_C6 ^ 16'($urandom_range(0, 4095)),
                                16'($urandom));
            1: load_calibration(pick_cal_word(), pick_cal_word(), pick_cal_word(),
                                pick_cal_word(), pick_cal_word(), pick_cal_word(),
                                16'($urandom));
            default: load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom));
         endcase
         if ($urandom_range(0, 3) == 0)
            write_cal_reg(CSR_UNUSED_IDX, 16'($urandom));
         n_items = $urandom_range(40, 64);
         for (int k = 0; k < n_items; k++)
            queue_sample(pick_pressure_raw(), pick_temperature_raw());
         wait_until_idle();
      end

      if (error_count == 0)
         $display("baro_pressure_temp_compensation verification clean");
      else
         $display("baro_pressure_temp_compensation verification failed");
      $finish;
   end

endmodule
